@@ hdl/ptts_pkg.sv @@
// Shared types and constants for the periodic task tick scheduler.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ptts_pkg;

  localparam int NUM_SLOTS_DEF = 8;
  localparam int ACT_W         = 3;
  localparam int ID_W          = 3;
  localparam int TIME_W        = 16;
  localparam int MAX_FIRES     = 8;
  localparam int FIRE_CNT_W    = $clog2(MAX_FIRES + 1);
  localparam int FIFO_DEPTH    = 16;
  localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);
  localparam int IN_TDATA_W    = 40;
  localparam int OUT_TDATA_W   = 8;

  // action codes
  localparam logic [ACT_W-1:0] ACT_TICK    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_CREATE  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_DELETE  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_SUSPEND = 3'd3;
  localparam logic [ACT_W-1:0] ACT_RESUME  = 3'd4;

  // controller -> datapath
  typedef struct packed {
    logic accept;    // input transaction taken this cycle
    logic start;     // tick accepted: rewind walk
    logic issue_rd;  // read slot at walk pointer
    logic flush;     // end of walk: emit held fire as last
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_is_tick;
    logic walk_last;
  } sts_t;

  // one queued result
  typedef struct packed {
    logic [ID_W-1:0] fired_task;
    logic            last_in_tick;
  } fire_t;

endpackage

@@ hdl/ptts_fifo.sv @@
// Result queue between the slot walk and the output channel.
// Depends on ptts_pkg.
`timescale 1ns / 1ps

module ptts_fifo
  import ptts_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  fire_t push_data,
  output logic  pop_valid,
  input  logic  pop_ready,
  output fire_t pop_data,
  output logic  room
);

  fire_t                 mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  pop;

  assign pop_valid = (cnt_r != '0);
  assign pop       = pop_valid && pop_ready;
  assign pop_data  = mem_r[rd_ptr_r];
  // a whole tick's worth of results must fit
  assign room      = (cnt_r <= FIFO_CNT_W'(FIFO_DEPTH - MAX_FIRES));

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ hdl/ptts_ctrl.sv @@
// Sequencer for the scheduler: input handshake and tick walk control.
// Depends on ptts_pkg.
`timescale 1ns / 1ps

module ptts_ctrl
  import ptts_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic fifo_room,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_WALK  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt    = state_r;
    in_tready    = 1'b0;
    cmd          = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready  = fifo_room;
        cmd.accept = in_tvalid && fifo_room;
        if (cmd.accept && sts.in_is_tick) begin
          cmd.start = 1'b1;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd.issue_rd = 1'b1;
        if (sts.walk_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FLUSH;
      end
      ST_FLUSH: begin
        cmd.flush = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hdl/ptts_dp.sv @@
// Slot table datapath: flags, period/countdown memories, walk pipeline.
// Depends on ptts_pkg.
`timescale 1ns / 1ps

module ptts_dp
  import ptts_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [ACT_W-1:0]  action,
  input  logic [ID_W-1:0]   task_id,
  input  logic [TIME_W-1:0] period,
  input  logic [TIME_W-1:0] first_delay,
  output logic              push,
  output fire_t             push_data
);

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic [NUM_SLOTS-1:0]  valid_r, valid_nxt;
  logic [NUM_SLOTS-1:0]  paused_r, paused_nxt;
  logic [TIME_W-1:0]     per_mem [NUM_SLOTS];
  logic [TIME_W-1:0]     cd_mem  [NUM_SLOTS];

  logic [SLOT_W-1:0]     rd_idx_r;
  logic                  s1_vld_r;
  logic [SLOT_W-1:0]     s1_idx_r;
  logic [TIME_W-1:0]     rd_per_r;
  logic [TIME_W-1:0]     rd_cd_r;
  logic [FIRE_CNT_W-1:0] fire_cnt_r;
  logic                  pend_vld_r;
  logic [ID_W-1:0]       pend_id_r;

  logic                  id_ok;
  logic [SLOT_W-1:0]     id_idx;
  logic                  cmd_we;
  logic                  create_we;
  logic                  s1_active;
  logic                  s1_due;
  logic                  fire;
  logic [TIME_W-1:0]     cd_new;
  logic [SLOT_W+2:0]     s1_idx_ext;
  logic [ID_W-1:0]       s1_id;

  assign sts.in_is_tick = (action == ACT_TICK);
  assign sts.walk_last  = (rd_idx_r == SLOT_W'(NUM_SLOTS - 1));

  assign id_ok     = (int'(task_id) < NUM_SLOTS);
  assign id_idx    = SLOT_W'(task_id);
  assign cmd_we    = cmd.accept && !sts.in_is_tick && id_ok;
  assign create_we = cmd_we && (action == ACT_CREATE);

  // slot flags
  always_comb begin
    valid_nxt  = valid_r;
    paused_nxt = paused_r;
    if (cmd_we) begin
      case (action)
        ACT_CREATE: begin
          valid_nxt[id_idx]  = 1'b1;
          paused_nxt[id_idx] = 1'b0;
        end
        ACT_DELETE:  valid_nxt[id_idx]  = 1'b0;
        ACT_SUSPEND: paused_nxt[id_idx] = 1'b1;
        ACT_RESUME:  paused_nxt[id_idx] = 1'b0;
        default: ;
      endcase
    end
  end

  // stage 1: one slot whose table entry came out of the memories
  assign s1_active  = s1_vld_r && valid_r[s1_idx_r] && !paused_r[s1_idx_r];
  assign s1_due     = (rd_cd_r == '0);
  assign cd_new     = s1_due ? rd_per_r - 1'b1 : rd_cd_r - 1'b1;
  assign fire       = s1_active && s1_due && (fire_cnt_r != FIRE_CNT_W'(MAX_FIRES));
  assign s1_idx_ext = (SLOT_W + 3)'(s1_idx_r);
  assign s1_id      = s1_idx_ext[ID_W-1:0];

  // one fire is held back until we know whether another follows
  always_comb begin
    push      = 1'b0;
    push_data = '0;
    if (pend_vld_r && (fire || cmd.flush)) begin
      push                   = 1'b1;
      push_data.fired_task   = pend_id_r;
      push_data.last_in_tick = cmd.flush;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      paused_r   <= '0;
      s1_vld_r   <= 1'b0;
      rd_idx_r   <= '0;
      fire_cnt_r <= '0;
      pend_vld_r <= 1'b0;
    end else begin
      valid_r  <= valid_nxt;
      paused_r <= paused_nxt;
      s1_vld_r <= cmd.issue_rd;
      if (cmd.start) begin
        rd_idx_r <= '0;
      end else if (cmd.issue_rd) begin
        rd_idx_r <= rd_idx_r + 1'b1;
      end
      if (cmd.start) begin
        fire_cnt_r <= '0;
        pend_vld_r <= 1'b0;
      end else if (fire) begin
        fire_cnt_r <= fire_cnt_r + 1'b1;
        pend_vld_r <= 1'b1;
      end else if (cmd.flush) begin
        pend_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r <= rd_idx_r;
    if (fire) begin
      pend_id_r <= s1_id;
    end
  end

  // table memories: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (create_we) begin
      per_mem[id_idx] <= period;
    end
    if (cmd.issue_rd) begin
      rd_per_r <= per_mem[rd_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (create_we) begin
      cd_mem[id_idx] <= first_delay;
    end else if (s1_active) begin
      cd_mem[s1_idx_r] <= cd_new;
    end
    if (cmd.issue_rd) begin
      rd_cd_r <= cd_mem[rd_idx_r];
    end
  end

endmodule

@@ hdl/periodic_task_tick_scheduler.sv @@
// Create/delete/suspend/resume take effect at the accept edge; commands run back to back.
// A tick holds off the input while it steps through accept, one slot per cycle through the
// registered table read, a drain state, and a state to release the held last result.
// Results reach a 16-entry queue; input is taken only while at least 8 entries are free.
// Reset (rst_n low, synchronous) clears slot valid/paused bits, the queue and the sequencer;
// period/countdown memories keep no reset and are loaded by create.
`timescale 1ns / 1ps

module periodic_task_tick_scheduler
  import ptts_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // command channel
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,  // [2:0] task_id, [18:3] period,
                                            // [34:19] first_delay, [39:35] zero
  input  logic [ACT_W-1:0]       in_tuser,  // [2:0] action
  // fire results
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata, // [2:0] fired_task, [7:3] zero
  output logic                   out_tlast  // last_in_tick
);

  cmd_t  cmd;
  sts_t  sts;
  logic  fifo_room;
  logic  push;
  fire_t push_data;
  fire_t pop_data;

  // Sequencer: one-hot FSM owning in_tready and walk timing.
  ptts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .fifo_room (fifo_room),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Slot table and the walk pipeline. Commands are applied directly from
  // the transaction payload; ticks walk the memories one slot per cycle.
  ptts_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .action      (in_tuser),
    .task_id     (in_tdata[2:0]),
    .period      (in_tdata[18:3]),
    .first_delay (in_tdata[34:19]),
    .push        (push),
    .push_data   (push_data)
  );

  // Result queue decouples the walk from output backpressure.
  ptts_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop_valid (out_tvalid),
    .pop_ready (out_tready),
    .pop_data  (pop_data),
    .room      (fifo_room)
  );

  assign out_tdata = OUT_TDATA_W'(pop_data.fired_task);
  assign out_tlast = pop_data.last_in_tick;

endmodule

@@ hdl/ptts_chk.sv @@
// Port-level checks for the scheduler, bound onto the top level.
// Depends on ptts_pkg and periodic_task_tick_scheduler.
`timescale 1ns / 1ps

module ptts_chk
  import ptts_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [ACT_W-1:0]       in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast
);

  // queue is empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("results visible after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // a tick occupies the block: no input taken in the following cycle
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == ACT_TICK) |=> !in_tready)
    else $error("input taken during a tick walk");

  // table commands produce no results
  a_cmd_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser != ACT_TICK) && !out_tvalid |=> !out_tvalid)
    else $error("result produced by a non-tick command");

endmodule

bind periodic_task_tick_scheduler ptts_chk u_ptts_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

@@ tb/sv/tb.sv @@
// Self-checking bench for periodic_task_tick_scheduler: directed and random command traffic.
// Depends on ptts_pkg (action codes, fire_t) and the scheduler top level.
`timescale 1ns / 1ps

module tb;
  import ptts_pkg::*;

  localparam int SLOTS       = NUM_SLOTS_DEF;
  localparam int HALF_PERIOD = 6;            // 12 ns clock
  localparam int RESET_CYC   = 7;
  localparam int TICK_LAT    = SLOTS + 3;    // tick walk length, from the sequencer states
  localparam int TAIL_CYC    = TICK_LAT + 8;
  localparam int CYCLE_LIMIT = 500000;
  localparam int RAND_PER_PHASE = 81;

  // codes the block must ignore
  localparam logic [ACT_W-1:0] ACT_SPARE_A = 3'd5;
  localparam logic [ACT_W-1:0] ACT_SPARE_B = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_C = 3'd7;

  // Mirror of the slot table: predicts fire transactions and checks them in order.
  class fire_tracker;
    bit                slot_on[SLOTS];
    bit                slot_held[SLOTS];
    logic [TIME_W-1:0] slot_per[SLOTS];
    logic [TIME_W-1:0] slot_cnt[SLOTS];
    fire_t             due_fires[$];
    int                mismatches;
    int                fires_seen;

    function new();
      for (int s = 0; s < SLOTS; s++) begin
        slot_on[s]   = 1'b0;
        slot_held[s] = 1'b0;
        slot_per[s]  = '0;
        slot_cnt[s]  = '0;
      end
      mismatches = 0;
      fires_seen = 0;
    endfunction

    function int pending();
      return due_fires.size();
    endfunction

    // Apply one accepted command; a tick queues its fires.
    function void note_command(logic [ACT_W-1:0] act, logic [ID_W-1:0] id,
                               logic [TIME_W-1:0] per, logic [TIME_W-1:0] dly);
      fire_t f;
      int    n;
      n = 0;
      if (act == ACT_TICK) begin
        for (int s = 0; s < SLOTS; s++) begin
          if (slot_on[s] && !slot_held[s]) begin
            if (slot_cnt[s] == '0) begin
              slot_cnt[s] = slot_per[s] - 1'b1;   // zero period wraps to all ones
              if (n < MAX_FIRES) begin
                f.fired_task   = s[ID_W-1:0];
                f.last_in_tick = 1'b0;
                due_fires.push_back(f);
                n++;
              end
            end else begin
              slot_cnt[s] = slot_cnt[s] - 1'b1;
            end
          end
        end
        if (n > 0) due_fires[due_fires.size()-1].last_in_tick = 1'b1;
      end else if (int'(id) < SLOTS) begin
        case (act)
          ACT_CREATE: begin
            slot_per[id]  = per;
            slot_cnt[id]  = dly;
            slot_on[id]   = 1'b1;
            slot_held[id] = 1'b0;
          end
          ACT_DELETE:  slot_on[id]   = 1'b0;   // period, count and pause kept
          ACT_SUSPEND: slot_held[id] = 1'b1;
          ACT_RESUME:  slot_held[id] = 1'b0;
          default: ;
        endcase
      end
    endfunction

    function void check_fire(logic [ID_W-1:0] task_no, logic last_flag);
      fire_t want;
      fires_seen++;
      if (due_fires.size() == 0) begin
        $error("unexpected fire: fired_task %0d last_in_tick %0d", task_no, last_flag);
        mismatches++;
      end else begin
        want = due_fires.pop_front();
        if (want.fired_task !== task_no) begin
          $error("fired_task expected %0d actual %0d", want.fired_task, task_no);
          mismatches++;
        end
        if (want.last_in_tick !== last_flag) begin
          $error("last_in_tick expected %0d actual %0d", want.last_in_tick, last_flag);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [ACT_W-1:0]       in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;

  fire_tracker sb;
  int tx_idle_pct = 23;   // sender idles this often (percent)
  int rx_idle_pct = 80;   // receiver stalls this often (percent)
  int cycles      = 0;
  int cmds_sent   = 0;
  int ticks_sent  = 0;

  periodic_task_tick_scheduler dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #HALF_PERIOD clk = ~clk;

  // Run guard: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver backpressure, redrawn every cycle.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Output monitor: every accepted fire transaction goes to the tracker.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_fire(out_tdata[ID_W-1:0], out_tlast);
  end

  // Present one command, with random idle cycles first; valid stays high on
  // back-to-back transactions.
  task automatic send_cmd(input logic [ACT_W-1:0] act, input logic [ID_W-1:0] id,
                          input logic [TIME_W-1:0] per, input logic [TIME_W-1:0] dly);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {5'b0, dly, per, id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_command(act, id, per, dly);
    cmds_sent++;
    if (act == ACT_TICK) ticks_sent++;
  endtask

  // Hold off the sender until every predicted fire has come out, then let
  // any walk in flight finish.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYC) @(posedge clk);
  endtask

  // Mostly short periods and delays so slots fire often; some full-range values.
  function automatic logic [TIME_W-1:0] pick_time(int small_max);
    if ($urandom_range(0, 99) < 75) return TIME_W'($urandom_range(0, small_max));
    return TIME_W'($urandom);
  endfunction

  task automatic send_random();
    logic [ACT_W-1:0]  act;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] per;
    logic [TIME_W-1:0] dly;
    int                roll;
    roll = $urandom_range(0, 99);
    id   = ID_W'($urandom);
    per  = TIME_W'($urandom);
    dly  = TIME_W'($urandom);
    if (roll < 42) begin
      act = ACT_TICK;               // id/period/delay left as noise
    end else if (roll < 67) begin
      act = ACT_CREATE;
      per = pick_time(5);
      dly = pick_time(6);
    end else if (roll < 76) begin
      act = ACT_DELETE;
    end else if (roll < 85) begin
      act = ACT_SUSPEND;
    end else if (roll < 94) begin
      act = ACT_RESUME;
    end else begin
      case ($urandom_range(0, 2))
        0:       act = ACT_SPARE_A;
        1:       act = ACT_SPARE_B;
        default: act = ACT_SPARE_C;
      endcase
    end
    send_cmd(act, id, per, dly);
  endtask

  initial begin
    sb = new();
    repeat (RESET_CYC) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-table tick, zero period wrap, extreme delays, pause on a
    // dead slot, delete keeping state, ignored codes, full eight-fire tick.
    send_cmd(ACT_TICK,    3'd0, 16'h0000, 16'h0000);
    send_cmd(ACT_CREATE,  3'd0, 16'h0000, 16'h0000);
    send_cmd(ACT_CREATE,  3'd1, 16'h0001, 16'h0000);
    send_cmd(ACT_CREATE,  3'd7, 16'hFFFF, 16'hFFFF);
    send_cmd(ACT_CREATE,  3'd3, 16'h0002, 16'h0001);
    send_cmd(ACT_TICK,    3'd7, 16'hFFFF, 16'hFFFF);
    send_cmd(ACT_TICK,    3'd0, 16'h0000, 16'h0000);
    send_cmd(ACT_SUSPEND, 3'd1, 16'h0000, 16'h0000);
    send_cmd(ACT_TICK,    3'd0, 16'h0000, 16'h0000);
    send_cmd(ACT_SUSPEND, 3'd5, 16'h0000, 16'h0000);
    send_cmd(ACT_RESUME,  3'd5, 16'h0000, 16'h0000);
    send_cmd(ACT_RESUME,  3'd1, 16'h0000, 16'h0000);
    send_cmd(ACT_DELETE,  3'd3, 16'h0000, 16'h0000);
    send_cmd(ACT_TICK,    3'd0, 16'h0000, 16'h0000);
    send_cmd(ACT_SPARE_A, 3'd7, 16'hFFFF, 16'hFFFF);
    send_cmd(ACT_SPARE_B, 3'd2, 16'hA5A5, 16'h5A5A);
    send_cmd(ACT_SPARE_C, 3'd4, 16'h0001, 16'h8000);
    for (int s = 0; s < SLOTS; s++) send_cmd(ACT_CREATE, ID_W'(s), 16'h0001, 16'h0000);
    send_cmd(ACT_TICK,    3'd0, 16'h0000, 16'h0000);
    drain();

    // Random traffic in three backpressure phases.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 23;
          rx_idle_pct = 80;
        end
        1: begin
          tx_idle_pct = 80;
          rx_idle_pct = 23;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        send_random();
        if (i == RAND_PER_PHASE / 2) drain();
      end
      drain();
    end

    $display("ran %0d commands including %0d ticks; %0d fire transactions checked",
             cmds_sent, ticks_sent, sb.fires_seen);
    $display("backpressure phases: slow receiver, slow sender, full rate");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/ptts_pkg.sv
hdl/ptts_fifo.sv
hdl/ptts_ctrl.sv
hdl/ptts_dp.sv
hdl/periodic_task_tick_scheduler.sv
hdl/ptts_chk.sv
tb/sv/tb.sv
